// ===== hdl/bdqs_pkg.sv =====
// ----------------------------------------------------------------------------
// bdqs_pkg
// Operation codes, status codes and the result beat layout of the deque unit.
// ----------------------------------------------------------------------------
package bdqs_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_FIND       = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] count;
    logic [7:0] position;
    logic       found;
  } result_t;

endpackage

// ===== hdl/bounded_deque_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit
// Bounded double-ended queue of 32-bit values in a ring memory, with push and
// pop at both ends and a linear find that reports the first match position.
// ----------------------------------------------------------------------------
// channel  dir  beat content
// in_      in   tuser: cmd[2:0]; tdata: value[31:0]
// out_     out  tdata: found[0], position[8:1], count[17:9]; tuser: status[1:0]
//
// Push and pop: the result is registered in the cycle after the beat is accepted.
// Find: the single memory read port scans one entry per cycle from the front
// and stops at the first match.
// Reset empties the queue; memory contents are not cleared.
// A result waiting on out_tready holds off the next input beat.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_unit
  import bdqs_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // found[0], position[8:1], count[17:9], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       out_res_r, out_res_nxt;
  result_t       res_r, res_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [IW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_off_r, cmp_off_nxt;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data_r;

  logic          accept;
  logic          out_free;
  logic          full;
  logic          empty;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [SW-1:0] back_sum;
  logic [SW-1:0] back_idx;
  logic [31:0]   cnt32;
  logic [31:0]   off32;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign back_sum  = SW'(front_r) + SW'(count_r);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.count, out_res_r.position, out_res_r.found};
  assign out_tuser  = out_res_r.status;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    res_nxt       = res_r;
    key_nxt       = key_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_cnt_nxt  = scan_cnt_r;
    cmp_vld_nxt   = 1'b0;
    cmp_off_nxt   = cmp_off_r;
    wr_en         = 1'b0;
    wr_addr       = back_idx[IW-1:0];
    cnt32         = 32'(count_r);
    off32         = 32'(cmp_off_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_res_nxt.found    = 1'b0;
          out_res_nxt.position = '0;
          out_res_nxt.status   = ST_OK;
          out_res_nxt.count    = cnt32[8:0];
          out_valid_nxt        = 1'b1;
          case (in_tuser)
            CMD_PUSH_FRONT: begin
              if (full) begin
                out_res_nxt.status = ST_PUSH_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                out_res_nxt.status = ST_PUSH_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                out_res_nxt.status = ST_POP_EMPTY;
              end else begin
                front_nxt = front_inc;
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                out_res_nxt.status = ST_POP_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_FIND: begin
              out_valid_nxt  = 1'b0;
              key_nxt        = in_tdata;
              scan_ptr_nxt   = front_r;
              scan_cnt_nxt   = '0;
              res_nxt        = '0;
              res_nxt.count  = cnt32[8:0];
              state_nxt      = S_FIND;
            end
            default: begin
            end
          endcase
          cnt32             = 32'(count_nxt);
          out_res_nxt.count = cnt32[8:0];
        end
      end
      S_FIND: begin
        if (cmp_vld_r && (rd_data_r == key_r)) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = off32[7:0];
          state_nxt        = S_DONE;
        end else if (scan_cnt_r < count_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_off_nxt  = scan_cnt_r[IW-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          scan_ptr_nxt = (scan_ptr_r == IW'(DEPTH - 1)) ? '0 : scan_ptr_r + 1'b1;
        end else if (!cmp_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_tdata;
    end
    rd_data_r <= mem[scan_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    res_r      <= res_nxt;
    key_r      <= key_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    cmp_off_r  <= cmp_off_nxt;
  end

endmodule

// ===== bench/deque_result_checker.sv =====
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches both stream channels of the deque unit. Every accepted input beat
// is applied to a shadow ring of the deque to work out the result that must
// come back; every accepted output beat is compared with the oldest one.
// ----------------------------------------------------------------------------
module deque_result_checker
  import bdqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // found[0], position[8:1], count[17:9]
  input  logic [1:0]  out_tuser,  // status[1:0]
  output int          fail_count,
  output int          outstanding,
  output int          checked,
  output int          find_hits,
  output int          full_drops,
  output int          empty_pops
);

  localparam int DEPTH = 256;

  logic [31:0] shadow_mem [0:DEPTH-1];
  logic [7:0]  shadow_front;
  logic [8:0]  shadow_fill;
  result_t     awaited_results [$];

  int n_fail  = 0;
  int n_check = 0;
  int n_hit   = 0;
  int n_full  = 0;
  int n_empty = 0;

  initial outstanding = 0;

  assign fail_count = n_fail;
  assign checked    = n_check;
  assign find_hits  = n_hit;
  assign full_drops = n_full;
  assign empty_pops = n_empty;

  task automatic predict_op(input logic [2:0] op, input logic [31:0] v, output result_t r);
    logic [7:0] slot;
    r = '0;
    case (op)
      CMD_PUSH_FRONT: begin
        if (shadow_fill == DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          shadow_front = shadow_front - 8'd1;
          shadow_mem[shadow_front] = v;
          shadow_fill++;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_fill == DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          slot = shadow_front + shadow_fill[7:0];
          shadow_mem[slot] = v;
          shadow_fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          shadow_front = shadow_front + 8'd1;
          shadow_fill--;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_fill == 0) r.status = ST_POP_EMPTY;
        else shadow_fill--;
      end
      CMD_FIND: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (i < shadow_fill && !r.found) begin
            slot = shadow_front + i[7:0];
            if (shadow_mem[slot] == v) begin
              r.found    = 1'b1;
              r.position = i[7:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_fill;
  endtask

  task automatic compare_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    int      delta;
    delta = 0;
    if (!rst_n) begin
      shadow_front = '0;
      shadow_fill  = '0;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.found    = out_tdata[0];
        got.position = out_tdata[8:1];
        got.count    = out_tdata[17:9];
        got.status   = out_tuser;
        delta--;
        if (awaited_results.size() == 0) begin
          n_fail++;
          $display("%0t: result beat with nothing expected, %s %0d pos %0d count %0d status %0d",
                   $time, "actual found", got.found, got.position, got.count, got.status);
        end else begin
          want = awaited_results.pop_front();
          n_check++;
          compare_field("found", int'(want.found), int'(got.found));
          compare_field("position", int'(want.position), int'(got.position));
          compare_field("count", int'(want.count), int'(got.count));
          compare_field("status", int'(want.status), int'(got.status));
          if (want.found) n_hit++;
          if (want.status == ST_PUSH_FULL) n_full++;
          if (want.status == ST_POP_EMPTY) n_empty++;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_op(in_tuser, in_tdata, want);
        awaited_results.push_back(want);
        delta++;
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

// ===== bench/tb_bounded_deque_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search_unit
// Drives operation beats into the deque unit: a directed opening on the
// corner values, random mixes, a fill to full and a drain to empty, with
// random gaps on the input and random stalls on the result channel. The
// checker beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search_unit;
  import bdqs_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;
  localparam int         CAPACITY    = 256;
  localparam int         ITEM_GOAL   = 950;
  localparam int         CYCLE_LIMIT = 1_500_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // value[31:0]
  logic [2:0]  in_tuser   = '0;   // cmd[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // found[0], position[8:1], count[17:9]
  logic [1:0]  out_tuser;         // status[1:0]

  int fail_count;
  int outstanding;
  int checked;
  int find_hits;
  int full_drops;
  int empty_pops;

  logic        calm        = 1'b0;
  int          stall_left  = 0;
  int          cycle_count = 0;
  int          sent        = 0;
  int          level       = 0;
  int          serial      = 0;
  logic [31:0] recent_vals [$];
  logic [31:0] last_back;

  bounded_deque_with_search_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  deque_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .find_hits   (find_hits),
    .full_drops  (full_drops),
    .empty_pops  (empty_pops)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, outstanding);
      $display("** bounded_deque_with_search_unit: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // result channel back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) < 25) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] fresh_value();
    serial++;
    return {16'($urandom_range(65535)), serial[15:0]};
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55 && recent_vals.size() != 0)
      return recent_vals[$urandom_range(recent_vals.size() - 1)];
    if (r < 62) return 32'h8000_0000;
    if (r < 69) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [31:0] v);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (level < CAPACITY) level++;
        recent_vals.push_back(v);
        if (recent_vals.size() > 64) void'(recent_vals.pop_front());
      end
      CMD_POP_FRONT, CMD_POP_BACK: if (level > 0) level--;
      default: ;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 20)      send_beat(CMD_PUSH_FRONT, pick_value());
    else if (r < 45) send_beat(CMD_PUSH_BACK, pick_value());
    else if (r < 60) send_beat(CMD_POP_FRONT, $urandom);
    else if (r < 75) send_beat(CMD_POP_BACK, $urandom);
    else if (r < 95) send_beat(CMD_FIND, pick_value());
    else if (r < 97) send_beat(CMD_SPARE_A, $urandom);
    else if (r < 98) send_beat(CMD_SPARE_B, $urandom);
    else             send_beat(CMD_SPARE_C, $urandom);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: empty cases, extreme values, first-match, spare codes
    send_beat(CMD_FIND, 32'h0000_0000);
    send_beat(CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_beat(CMD_POP_BACK, 32'h0000_0000);
    send_beat(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_beat(CMD_PUSH_FRONT, 32'h8000_0000);
    send_beat(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_beat(CMD_PUSH_FRONT, 32'h0000_0000);
    send_beat(CMD_FIND, 32'h0000_0000);
    send_beat(CMD_FIND, 32'h8000_0000);
    send_beat(CMD_FIND, 32'h7FFF_FFFF);
    send_beat(CMD_FIND, 32'hFFFF_FFFF);
    send_beat(CMD_FIND, 32'h7FFF_FFFE);
    send_beat(CMD_PUSH_BACK, 32'h8000_0000);
    send_beat(CMD_FIND, 32'h8000_0000);
    send_beat(CMD_SPARE_A, 32'hFFFF_FFFF);
    send_beat(CMD_SPARE_B, 32'h0000_0000);
    send_beat(CMD_SPARE_C, 32'h8000_0000);
    send_beat(CMD_POP_FRONT, 32'h0000_0000);
    send_beat(CMD_POP_BACK, 32'h0000_0000);
    send_beat(CMD_FIND, 32'hFFFF_FFFF);
    repeat (3) send_beat(CMD_POP_FRONT, $urandom);
    send_beat(CMD_POP_BACK, $urandom);

    repeat (200) random_beat();
    wait_drained();

    // fill to full, last push at the back so it sits at the deepest position
    while (level < CAPACITY) begin
      if (level == CAPACITY - 1) begin
        last_back = fresh_value();
        send_beat(CMD_PUSH_BACK, last_back);
      end else begin
        send_beat($urandom_range(3) == 0 ? CMD_PUSH_FRONT : CMD_PUSH_BACK, fresh_value());
      end
    end
    repeat (2) begin
      send_beat(CMD_PUSH_FRONT, $urandom);
      send_beat(CMD_PUSH_BACK, $urandom);
    end
    send_beat(CMD_FIND, last_back);
    repeat (3) send_beat(CMD_FIND, $urandom);
    repeat (20) send_beat(CMD_FIND, pick_value());

    // drain past empty
    while (level > 0) begin
      send_beat($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
      if ($urandom_range(15) == 0) send_beat(CMD_FIND, pick_value());
    end
    send_beat(CMD_POP_FRONT, $urandom);
    send_beat(CMD_POP_BACK, $urandom);
    send_beat(CMD_FIND, pick_value());

    calm <= 1'b1;
    repeat (60) random_beat();
    calm <= 1'b0;
    while (sent < ITEM_GOAL) random_beat();

    wait_drained();
    repeat (30) @(posedge clk);

    $display("Ran %0d operation beats, %0d results checked, including a fill to full and drain.",
             sent, checked);
    $display("Finds hit %0d times; %0d pushes dropped on full; %0d pops on empty.",
             find_hits, full_drops, empty_pops);
    if (fail_count == 0) begin
      $display("** bounded_deque_with_search_unit: PASSED **");
    end else begin
      $display("** bounded_deque_with_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
